// File: rtl/visibility_pixel_colorizer_top_macros.svh
// Assertion macros shared by the colorizer pipeline modules.
`ifndef VISIBILITY_PIXEL_COLORIZER_TOP_MACROS_SVH
`define VISIBILITY_PIXEL_COLORIZER_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define VPC_ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define VPC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/vpc_pkg.sv
// Shared constants, stage payload types and the divider step for the pixel colorizer.
`default_nettype none

package vpc_pkg;

  // Low 24 bits of the golden-ratio hash multiplier; only hash bits 23..0 are used
  localparam logic [23:0] HASH_MULT_LO = 24'h3779B1;
  localparam logic [15:0] DEPTH_MAX    = 16'hFFFF;
  localparam logic [15:0] SHADE_SPAN   = 16'd42598;
  localparam logic [16:0] SHADE_BASE   = 17'd22938;
  localparam logic [16:0] SHADE_ONE    = 17'd65536;
  localparam logic [16:0] DEPTH_DIV    = 17'd65535;
  localparam logic [7:0]  BG_RED       = 8'd4;
  localparam logic [7:0]  BG_GREEN     = 8'd6;
  localparam logic [7:0]  BG_BLUE      = 8'd12;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  // Quotient has 8 bits: 4 divider stages of 2 steps each
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = 2;

  // Raw hash color with its normalizer and shade
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  max_chan;
    logic [16:0] shade;
    logic        bg;
    logic        eof;
  } vpc_color_t;

  // Divider working words: remainder in [15:8], dividend/quotient bits in [7:0]
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [7:0]  max_chan;
    logic        bg;
    logic        eof;
  } vpc_div_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits
  function automatic logic [15:0] div_step(input logic [15:0] w, input logic [7:0] divisor);
    logic [8:0] cand;
    logic [8:0] diff;
    logic       take;
    logic [7:0] rem;
    cand = w[15:7];
    diff = cand - {1'b0, divisor};
    take = (cand >= {1'b0, divisor});
    rem  = take ? diff[7:0] : cand[7:0];
    return {rem, w[6:0], take};
  endfunction

endpackage

`default_nettype wire

// File: rtl/vpc_hash_stage.sv
// Front end: cluster hash, depth shade and channel maximum over two register stages.
`default_nettype none
`include "visibility_pixel_colorizer_top_macros.svh"

module vpc_hash_stage
  import vpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] pixel_word,
  input  wire logic        end_of_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output vpc_color_t       out_data
);

  logic [15:0] cid;
  logic [15:0] depth;
  logic [15:0] depth_inv;
  logic [39:0] hash_full;
  logic [31:0] span_full;

  logic        s1_valid;
  logic [23:0] s1_hash;
  logic [31:0] s1_span;
  logic        s1_bg;
  logic        s1_eof;

  logic        s1_en;
  logic        s2_en;

  logic [7:0]  ch_r;
  logic [7:0]  ch_g;
  logic [7:0]  ch_b;
  logic [7:0]  max_rg;
  logic [7:0]  max_rgb;
  logic [7:0]  max_chan;
  logic [16:0] fix_rem;
  logic [15:0] span_q;
  logic [16:0] shade;

  // Advance a stage when it is empty or its successor advances
  assign s2_en    = !out_valid || out_ready;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;

  // Stage 1: hash multiply and shade span multiply
  assign cid       = pixel_word[15:0];
  assign depth     = pixel_word[31:16];
  assign depth_inv = DEPTH_MAX - depth;
  assign hash_full = 40'(cid) * 40'(HASH_MULT_LO);
  assign span_full = 32'(SHADE_SPAN) * 32'(depth_inv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_hash <= hash_full[23:0];
      s1_span <= span_full;
      s1_bg   <= (cid == 16'd0) && (depth == DEPTH_MAX);
      s1_eof  <= end_of_frame;
    end
  end

  // Stage 2: split channels, take the maximum, divide span by 65535
  assign ch_r     = s1_hash[23:16];
  assign ch_g     = s1_hash[15:8];
  assign ch_b     = s1_hash[7:0];
  assign max_rg   = (ch_r > ch_g) ? ch_r : ch_g;
  assign max_rgb  = (max_rg > ch_b) ? max_rg : ch_b;
  assign max_chan = (max_rgb == 8'd0) ? 8'd1 : max_rgb;

  // x / 65535: quotient estimate x>>16, remainder (x mod 2^16) + estimate, one fixup
  assign fix_rem = {1'b0, s1_span[15:0]} + {1'b0, s1_span[31:16]};
  assign span_q  = s1_span[31:16] + 16'(fix_rem >= DEPTH_DIV);
  assign shade   = SHADE_BASE + {1'b0, span_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      out_data.red      <= ch_r;
      out_data.green    <= ch_g;
      out_data.blue     <= ch_b;
      out_data.max_chan <= max_chan;
      out_data.shade    <= shade;
      out_data.bg       <= s1_bg;
      out_data.eof      <= s1_eof;
    end
  end

  `VPC_ASSERT_IMPLIES(a_max_bounds, clk, rst, out_valid, (out_data.max_chan != 8'd0) && (out_data.max_chan >= out_data.red) && (out_data.max_chan >= out_data.green) && (out_data.max_chan >= out_data.blue), "channel maximum below a channel")
  `VPC_ASSERT_IMPLIES(a_shade_range, clk, rst, out_valid, (out_data.shade >= SHADE_BASE) && (out_data.shade <= SHADE_ONE), "shade out of range")

endmodule

`default_nettype wire

// File: rtl/vpc_scale_stage.sv
// Middle: shade each channel and scale to 255 over two register stages.
`default_nettype none
`include "visibility_pixel_colorizer_top_macros.svh"

module vpc_scale_stage
  import vpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire vpc_color_t  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output vpc_div_t         out_data
);

  logic        s3_valid;
  logic [24:0] s3_prod_r;
  logic [24:0] s3_prod_g;
  logic [24:0] s3_prod_b;
  logic [7:0]  s3_max;
  logic        s3_bg;
  logic        s3_eof;

  logic        s3_en;
  logic        s4_en;

  logic [32:0] full_r;
  logic [32:0] full_g;
  logic [32:0] full_b;

  // Advance a stage when it is empty or its successor advances
  assign s4_en    = !out_valid || out_ready;
  assign s3_en    = !s3_valid || s4_en;
  assign in_ready = s3_en;

  // Stage 3: channel times shade
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && in_valid) begin
      s3_prod_r <= 25'(in_data.red) * 25'(in_data.shade);
      s3_prod_g <= 25'(in_data.green) * 25'(in_data.shade);
      s3_prod_b <= 25'(in_data.blue) * 25'(in_data.shade);
      s3_max    <= in_data.max_chan;
      s3_bg     <= in_data.bg;
      s3_eof    <= in_data.eof;
    end
  end

  // Stage 4: times 255 as shift minus one, then drop the Q16 fraction
  assign full_r = {s3_prod_r, 8'd0} - {8'd0, s3_prod_r};
  assign full_g = {s3_prod_g, 8'd0} - {8'd0, s3_prod_g};
  assign full_b = {s3_prod_b, 8'd0} - {8'd0, s3_prod_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en && s3_valid) begin
      out_data.red      <= full_r[31:16];
      out_data.green    <= full_g[31:16];
      out_data.blue     <= full_b[31:16];
      out_data.max_chan <= s3_max;
      out_data.bg       <= s3_bg;
      out_data.eof      <= s3_eof;
    end
  end

  // The divider needs the quotient to fit 8 bits: upper dividend byte below the divisor
  `VPC_ASSERT_IMPLIES(a_div_premise, clk, rst, out_valid, (out_data.red[15:8] < out_data.max_chan) && (out_data.green[15:8] < out_data.max_chan) && (out_data.blue[15:8] < out_data.max_chan), "scaled channel overflows quotient")

endmodule

`default_nettype wire

// File: rtl/vpc_div_stage.sv
// One divider pipeline stage: two restoring steps on all three channels.
`default_nettype none
`include "visibility_pixel_colorizer_top_macros.svh"

module vpc_div_stage
  import vpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire vpc_div_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output vpc_div_t      out_data
);

  logic     stage_en;
  vpc_div_t step_data;

  assign stage_en = !out_valid || out_ready;
  assign in_ready = stage_en;

  // Run this stage's share of quotient bits
  always_comb begin
    step_data = in_data;
    for (int i = 0; i < DIV_STEPS; i++) begin
      step_data.red   = div_step(step_data.red, in_data.max_chan);
      step_data.green = div_step(step_data.green, in_data.max_chan);
      step_data.blue  = div_step(step_data.blue, in_data.max_chan);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en && in_valid) begin
      out_data <= step_data;
    end
  end

  // Partial remainders always stay below the divisor
  `VPC_ASSERT_IMPLIES(a_rem_below_div, clk, rst, out_valid, (out_data.red[15:8] < out_data.max_chan) && (out_data.green[15:8] < out_data.max_chan) && (out_data.blue[15:8] < out_data.max_chan), "divider remainder not below divisor")

endmodule

`default_nettype wire

// File: rtl/visibility_pixel_colorizer_top.sv
// Pixel colorizer: usage
//   Input channel pixel_valid/pixel_ready carries pixel_word (depth in bits 31..16,
//   cluster id in bits 15..0) and end_of_frame. A request is taken at a clock edge
//   with pixel_valid and pixel_ready both high.
//   Output channel color_valid/color_ready carries red, green, blue, alpha (always
//   255) and frame_done, a copy of end_of_frame. Exactly one result per pixel, in order.
//   Stages from input request to color_valid, in order: hash and shade stages,
//   channel scaling stages, 4 divider stages (2 quotient bits each against
//   the channel maximum), then background select and output register.
//   Throughput: one pixel per clock; every stage advances each cycle while color_ready
//   is high.
//   Every stage carries its own valid bit; pixel_ready is high whenever some stage
//   has room, so requests keep flowing into bubbles while a result waits.
//   When the receiver holds color_ready low, the output holds its result and the
//   pipeline fills up; nothing is lost or repeated.
//   Synchronous active-high rst empties all stages; no state survives between pixels.
`default_nettype none

module visibility_pixel_colorizer_top
  import vpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pixel_valid,
  output logic             pixel_ready,
  input  wire logic [31:0] pixel_word,
  input  wire logic        end_of_frame,
  output logic             color_valid,
  input  wire logic        color_ready,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic             frame_done
);

  vpc_color_t color_data;
  logic       color_v;
  logic       color_rdy;

  vpc_div_t   div_data  [DIV_STAGES+1];
  logic       div_v     [DIV_STAGES+1];
  logic       div_rdy   [DIV_STAGES+1];

  logic       out_en;

  // Hash, shade and channel maximum
  vpc_hash_stage u_hash (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pixel_valid),
    .in_ready     (pixel_ready),
    .pixel_word   (pixel_word),
    .end_of_frame (end_of_frame),
    .out_valid    (color_v),
    .out_ready    (color_rdy),
    .out_data     (color_data)
  );

  // Shade and scale to 255
  vpc_scale_stage u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (color_v),
    .in_ready  (color_rdy),
    .in_data   (color_data),
    .out_valid (div_v[0]),
    .out_ready (div_rdy[0]),
    .out_data  (div_data[0])
  );

  // Divide by the channel maximum, a few quotient bits per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    vpc_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_v[s]),
      .in_ready  (div_rdy[s]),
      .in_data   (div_data[s]),
      .out_valid (div_v[s+1]),
      .out_ready (div_rdy[s+1]),
      .out_data  (div_data[s+1])
    );
  end

  // Output register: pick background color or quotients
  assign out_en                = !color_valid || color_ready;
  assign div_rdy[DIV_STAGES]   = out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (out_en) begin
      color_valid <= div_v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && div_v[DIV_STAGES]) begin
      red        <= div_data[DIV_STAGES].bg ? BG_RED   : div_data[DIV_STAGES].red[7:0];
      green      <= div_data[DIV_STAGES].bg ? BG_GREEN : div_data[DIV_STAGES].green[7:0];
      blue       <= div_data[DIV_STAGES].bg ? BG_BLUE  : div_data[DIV_STAGES].blue[7:0];
      frame_done <= div_data[DIV_STAGES].eof;
    end
  end

  assign alpha = ALPHA_OPAQUE;

endmodule

`default_nettype wire
